FILE: rtl/spfa_pkg.sv
// Package for the single-precision float adder: field widths and constants.
// No dependencies; used by spfa_datapath.
package spfa_pkg;
  localparam int WordW    = 32;
  localparam int ExpW     = 8;
  localparam int FracW    = 23;
  localparam int MantW    = 24;
  localparam int MaxAlign = 40;
  localparam int ExtW     = 64;
  localparam logic [23:0] HiddenBit = 24'h800000;
  localparam logic [31:0] InfMag    = 32'h7F800000;
  localparam logic [31:0] SignBit   = 32'h80000000;
endpackage

FILE: rtl/spfa_datapath.sv
// Combinational add/round datapath for one operand pair.
// Depends on spfa_pkg.
module spfa_datapath (
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  output logic [31:0] sum_out
);
  logic        a_inf, b_inf, a_zero, b_zero, a_nan, swap;
  logic [31:0] a, b;
  logic [7:0]  ea, eb, e1, e2;
  logic        s1, s2, diff, g, r, st, carry, negated, sign;
  logic [23:0] m1, m2, p, shifted, neg2;
  logic [5:0]  d;
  logic [7:0]  draw;
  logic [63:0] ext, lowmask;
  logic [24:0] sum;
  logic [4:0]  k;
  logic        kfound;
  logic [24:0] pr;
  logic signed [10:0] expo;
  logic [7:0]  ef;

  always_comb begin
    ea = (a_in[30:23] == 8'd0) ? 8'd1 : a_in[30:23];
    eb = (b_in[30:23] == 8'd0) ? 8'd1 : b_in[30:23];
    a_inf  = (a_in[30:0] == spfa_pkg::InfMag[30:0]);
    b_inf  = (b_in[30:0] == spfa_pkg::InfMag[30:0]);
    a_zero = (a_in[30:0] == 31'd0);
    b_zero = (b_in[30:0] == 31'd0);
    a_nan  = (a_in[30:23] == 8'hFF) && (a_in[22:0] != 23'd0);
    swap = ea < eb;
    a  = swap ? b_in : a_in;
    b  = swap ? a_in : b_in;
    e1 = swap ? eb : ea;
    e2 = swap ? ea : eb;
    s1 = a[31];
    s2 = b[31];
    diff = s1 != s2;
    m1 = {(a[30:23] != 8'd0), a[22:0]};
    m2 = {(b[30:23] != 8'd0), b[22:0]};
    draw = e1 - e2;
    d = (draw > 8'(spfa_pkg::MaxAlign)) ? 6'(spfa_pkg::MaxAlign) : draw[5:0];
    neg2 = 24'd0 - m2;
    // sign-extended operand, shifted below for alignment
    ext = diff ? {40'hFF_FFFF_FFFF, neg2} : {40'd0, m2};
    g = (d >= 6'd1) ? ext[d - 6'd1] : 1'b0;
    r = (d >= 6'd2) ? ext[d - 6'd2] : 1'b0;
    lowmask = (64'd1 << (d - 6'd2)) - 64'd1;
    st = (d >= 6'd3) ? ((ext & lowmask) != 64'd0) : 1'b0;
    shifted = 24'(ext >> d);
    sum = {1'b0, shifted} + {1'b0, m1};
    carry = sum[24];
    p = sum[23:0];
    negated = diff && !carry;
    if (negated) p = 24'd0 - p;
    expo = 11'(e1);
    // leading-one search
    k = 5'd0;
    kfound = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!kfound && p[i]) begin
        k = 5'(23 - i);
        kfound = 1'b1;
      end
    end
    sum_out = 32'd0;
    if (!diff && carry) begin
      st = g | r | st;
      r = p[0];
      p = {1'b1, p[23:1]};
      expo = expo + 11'sd1;
    end else begin
      if (!kfound) k = 5'd24;
      if (k == 5'd0) begin
        st = r | st;
        r = g;
      end else begin
        if (k > 5'd1) begin
          r = 1'b0;
          st = 1'b0;
        end
        p = 24'({p, g} << (k - 5'd1));
      end
      expo = expo - 11'(k);
    end
    // round to nearest even
    pr = {1'b0, p};
    if (r && (st || p[0])) pr = pr + 25'd1;
    if (pr[24]) begin
      pr = {1'b0, spfa_pkg::HiddenBit};
      expo = expo + 11'sd1;
    end
    sign = negated ? s2 : s1;
    ef = (expo <= 11'sd0) ? 8'd1 : expo[7:0];
    if (expo >= 11'sd255) sum_out = {sign, spfa_pkg::InfMag[30:0]};
    else sum_out = {sign, ef, pr[22:0]};
    if (!(!diff && carry) && !kfound && !g) sum_out = 32'd0;
    // special operands take priority
    if (a_inf) sum_out = a_in;
    else if (b_inf) sum_out = b_in;
    else if ((a_zero && b_zero) || ((a_in ^ b_in) == spfa_pkg::SignBit && !a_nan))
      sum_out = 32'd0;
    else if (a_zero) sum_out = b_in;
    else if (b_zero) sum_out = a_in;
  end
endmodule

FILE: rtl/single_precision_float_adder_core.sv
// Single-precision float adder: input register, datapath, output register.
// Depends on spfa_pkg and spfa_datapath.
//
// Usage: operand_a/operand_b come in on in_valid/in_stall; sum_bits
// leaves on out_valid/out_stall. A transaction happens when valid is high
// and stall is low.
// The sum passes through the input register, the datapath and the result
// register on its way to sum_bits. Throughput: one pair per cycle while
// out_stall is low, set by the single-pass datapath.
// Each stage moves on when the stage after it is empty or draining, so
// in_stall rises only when both stages hold data and out_stall is high.
// Stalled results hold their value. Reset empties both stages.
module single_precision_float_adder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sum_bits
);
  logic        s1_valid, s1_adv, s2_adv;
  logic [31:0] s1_a, s1_b, sum_comb;

  assign s2_adv   = !out_valid || !out_stall;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s1_adv) s1_valid <= in_valid;
    if (s1_adv && in_valid) begin
      s1_a <= operand_a;
      s1_b <= operand_b;
    end
  end

  spfa_datapath u_dp (.a_in(s1_a), .b_in(s1_b), .sum_out(sum_comb));

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s2_adv) out_valid <= s1_valid;
    if (s2_adv && s1_valid) sum_bits <= sum_comb;
  end
endmodule

FILE: rtl/spfa_checker.sv
// Port-level checker for the float adder, bound to the top level.
// Depends on single_precision_float_adder_core ports only.
module spfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] sum_bits
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_bits)) else $error("result changed");
  // input stalls only when output is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious stall");
  // empty after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");
  // accepted item reaches the output when out_stall stays low
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing");
endmodule

bind single_precision_float_adder_core spfa_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
);
